// ----- rtl/max_flow_min_cut_engine_top_macros.svh -----
// ----------------------------------------------------------------------------
// max flow engine assertion macros
// shared property shorthands for the engine's modules
// ----------------------------------------------------------------------------
`ifndef MAX_FLOW_MIN_CUT_ENGINE_TOP_MACROS_SVH
`define MAX_FLOW_MIN_CUT_ENGINE_TOP_MACROS_SVH

// same-cycle implication
`define MFMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mfmc assertion failed");

// next-cycle implication
`define MFMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mfmc assertion failed");

`endif

// ----- rtl/mfmc_pkg.sv -----
// ----------------------------------------------------------------------------
// mfmc_pkg
// types and constants shared by the max flow engine
// ----------------------------------------------------------------------------
package mfmc_pkg;

	localparam int NODE_W = 6;
	localparam int CAP_W  = 30;
	localparam int FLOW_W = 32;
	localparam int NC_W   = 7;

	localparam int DEF_MAX_NODES = 64;
	localparam int DEF_MAX_EDGES = 1024;

	localparam logic [CAP_W-1:0] INF_CAP        = 30'd1000000007;
	localparam logic [NC_W-1:0]  NODE_COUNT_RST = 7'd64;

	typedef enum logic {
		FUNC_ADD = 1'b0,
		FUNC_RUN = 1'b1
	} func_t;

	typedef struct packed {
		func_t             func;
		logic [NODE_W-1:0] from_node;
		logic [NODE_W-1:0] to_node;
		logic [CAP_W-1:0]  capacity;
		logic [NODE_W-1:0] source_node;
		logic [NODE_W-1:0] sink_node;
	} in_item_t;

	typedef struct packed {
		logic [FLOW_W-1:0] flow_total;
		logic [NODE_W-1:0] node_index;
		logic              source_side;
		logic              edge_overflow;
		logic              last;
	} out_item_t;

	// one table word holds an edge and its reverse companion as residuals
	typedef struct packed {
		logic [NODE_W-1:0] u;
		logic [NODE_W-1:0] v;
		logic [CAP_W-1:0]  r0;
		logic [CAP_W-1:0]  r1;
	} pair_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_INIT,
		S_DEQ,
		S_LOAD,
		S_SRD,
		S_E0,
		S_E1,
		S_AUG,
		S_APAR,
		S_AEDGE,
		S_AUPD,
		S_REP
	} state_t;

	typedef struct packed {
		logic add;
		logic run_load;
		logic clr_seen;
		logic init_search;
		logic load_u;
		logic eval;
		logic half;
		logic pair_next;
		logic aug_start;
		logic edge_rd;
		logic aug_upd;
		logic rep_load;
	} cmd_t;

	typedef struct packed {
		logic src_ok;
		logic q_empty;
		logic scan_end;
		logic found;
		logic at_src;
		logic rep_last;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/mfmc_ram.sv -----
// ----------------------------------------------------------------------------
// mfmc_ram
// simple dual port ram, one write and one registered read
// ----------------------------------------------------------------------------
module mfmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/mfmc_datapath.sv -----
// ----------------------------------------------------------------------------
// mfmc_datapath
// edge table, search queue, tree links, flow sum and result register
// ----------------------------------------------------------------------------
`include "max_flow_min_cut_engine_top_macros.svh"

module mfmc_datapath import mfmc_pkg::*; #(
	parameter int MAX_NODES = DEF_MAX_NODES,
	parameter int MAX_EDGES = DEF_MAX_EDGES
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cmd_t            cmd,
	output sts_t            sts,
	input  in_item_t        in_data,
	input  logic            cfg_we,
	input  logic [NC_W-1:0] cfg_wdata,
	output logic            out_valid,
	input  logic            out_ready,
	output out_item_t       out_data
);

	localparam int PAIRS = MAX_EDGES / 2;
	localparam int PW    = PAIRS > 1 ? $clog2(PAIRS) : 1;
	localparam int PCW   = $clog2(PAIRS + 1);
	localparam int EW    = PW + 1;
	localparam int QW    = MAX_NODES > 1 ? $clog2(MAX_NODES) : 1;
	localparam int QCW   = $clog2(MAX_NODES + 1);
	localparam int QEW   = NODE_W + CAP_W;
	localparam int PRW   = $bits(pair_t);

	logic [NC_W-1:0]      node_cnt_q;
	logic [NC_W-1:0]      n_eff;
	logic [PCW-1:0]       pair_cnt_q;
	logic                 overflow_q;
	logic                 full;
	logic [NODE_W-1:0]    src_q;
	logic [NODE_W-1:0]    snk_q;
	logic [FLOW_W-1:0]    total_q;
	logic [FLOW_W:0]      sum;
	logic [CAP_W-1:0]     df_q;
	logic [QCW-1:0]       qh_q;
	logic [QCW-1:0]       qt_q;
	logic [NODE_W-1:0]    u_q;
	logic [CAP_W-1:0]     bn_q;
	logic [PCW-1:0]       p_q;
	logic [MAX_NODES-1:0] seen_q;
	logic [NODE_W-1:0]    cur_q;
	logic [EW-1:0]        e_q;
	logic [NODE_W-1:0]    rep_q;
	logic                 out_valid_q;
	out_item_t            out_data_q;
	logic                 aug_mode;
	logic                 rep_last;

	logic              pair_we;
	logic [PW-1:0]     pair_waddr;
	pair_t             pair_wdata;
	logic [PW-1:0]     pair_raddr;
	logic [PRW-1:0]    pair_rdata;
	pair_t             pr;
	pair_t             upd;
	logic              q_we;
	logic [QW-1:0]     q_waddr;
	logic [QEW-1:0]    q_wdata;
	logic [QEW-1:0]    q_rdata;
	logic [EW-1:0]     par_rdata;

	logic [NODE_W-1:0] ev_tail;
	logic [NODE_W-1:0] ev_head;
	logic [CAP_W-1:0]  ev_res;
	logic [CAP_W-1:0]  ev_bn;
	logic              hit;

	always_comb begin
		if (node_cnt_q < NC_W'(2)) begin
			n_eff = NC_W'(2);
		end else if (int'(node_cnt_q) > MAX_NODES) begin
			n_eff = NC_W'(MAX_NODES);
		end else begin
			n_eff = node_cnt_q;
		end
	end

	assign full     = pair_cnt_q == PCW'(PAIRS);
	assign aug_mode = ({1'b0, snk_q} < n_eff) && (snk_q != src_q);
	assign rep_last = (NC_W'({1'b0, rep_q}) + NC_W'(1)) == n_eff;
	assign pr       = pair_t'(pair_rdata);

	// edge under test: the even slot runs u to v, the odd one v to u
	always_comb begin
		ev_tail = cmd.half ? pr.v : pr.u;
		ev_head = cmd.half ? pr.u : pr.v;
		ev_res  = cmd.half ? pr.r1 : pr.r0;
		ev_bn   = (bn_q < ev_res) ? bn_q : ev_res;
		hit     = cmd.eval && (ev_tail == u_q) && ({1'b0, ev_head} < n_eff)
			&& !seen_q[QW'(ev_head)] && (ev_res != '0);
	end

	always_comb begin
		upd = pr;
		if (!e_q[0]) begin
			upd.r0 = pr.r0 - df_q;
			upd.r1 = pr.r1 + df_q;
		end else begin
			upd.r0 = pr.r0 + df_q;
			upd.r1 = pr.r1 - df_q;
		end
	end

	always_comb begin
		pair_we    = 1'b0;
		pair_waddr = pair_cnt_q[PW-1:0];
		pair_wdata = '{u: in_data.from_node, v: in_data.to_node,
			r0: in_data.capacity, r1: '0};
		if (cmd.add && !full) begin
			pair_we = 1'b1;
		end else if (cmd.aug_upd) begin
			pair_we    = 1'b1;
			pair_waddr = e_q[EW-1:1];
			pair_wdata = upd;
		end
	end

	assign pair_raddr = cmd.edge_rd ? par_rdata[EW-1:1] : p_q[PW-1:0];
	assign q_we       = cmd.init_search || hit;
	assign q_waddr    = cmd.init_search ? '0 : qt_q[QW-1:0];
	assign q_wdata    = cmd.init_search ? {src_q, INF_CAP} : {ev_head, ev_bn};
	assign sum        = {1'b0, total_q} + (FLOW_W+1)'(df_q);

	mfmc_ram #(.WIDTH(PRW), .DEPTH(PAIRS)) u_pair_ram (
		.clk   (clk),
		.we    (pair_we),
		.waddr (pair_waddr),
		.wdata (pair_wdata),
		.raddr (pair_raddr),
		.rdata (pair_rdata)
	);

	mfmc_ram #(.WIDTH(QEW), .DEPTH(MAX_NODES)) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (qh_q[QW-1:0]),
		.rdata (q_rdata)
	);

	mfmc_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_parent_ram (
		.clk   (clk),
		.we    (hit),
		.waddr (QW'(ev_head)),
		.wdata ({p_q[PW-1:0], cmd.half}),
		.raddr (QW'(cur_q)),
		.rdata (par_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_cnt_q  <= NODE_COUNT_RST;
			pair_cnt_q  <= '0;
			overflow_q  <= 1'b0;
			total_q     <= '0;
			qh_q        <= '0;
			qt_q        <= '0;
			p_q         <= '0;
			seen_q      <= '0;
			rep_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				node_cnt_q <= cfg_wdata;
			end
			if (cmd.add) begin
				if (full) begin
					overflow_q <= 1'b1;
				end else begin
					pair_cnt_q <= pair_cnt_q + PCW'(1);
				end
			end
			if (cmd.run_load) begin
				total_q <= '0;
				rep_q   <= '0;
			end
			if (cmd.clr_seen) begin
				seen_q <= '0;
			end
			if (cmd.init_search) begin
				seen_q <= MAX_NODES'(1) << src_q;
				qh_q   <= '0;
				qt_q   <= QCW'(1);
			end
			if (cmd.load_u) begin
				qh_q <= qh_q + QCW'(1);
				p_q  <= '0;
			end
			if (hit) begin
				seen_q[QW'(ev_head)] <= 1'b1;
				qt_q                 <= qt_q + QCW'(1);
			end
			if (cmd.pair_next) begin
				p_q <= p_q + PCW'(1);
			end
			if (cmd.aug_start) begin
				total_q <= sum[FLOW_W] ? '1 : sum[FLOW_W-1:0];
			end
			if (cmd.rep_load) begin
				rep_q       <= rep_q + NODE_W'(1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.run_load) begin
			src_q <= in_data.source_node;
			snk_q <= in_data.sink_node;
		end
		if (cmd.load_u) begin
			u_q  <= q_rdata[QEW-1:CAP_W];
			bn_q <= q_rdata[CAP_W-1:0];
		end
		if (hit) begin
			df_q <= ev_bn;
		end
		if (cmd.aug_start) begin
			cur_q <= snk_q;
		end else if (cmd.aug_upd) begin
			cur_q <= e_q[0] ? pr.v : pr.u;
		end
		if (cmd.edge_rd) begin
			e_q <= par_rdata;
		end
		if (cmd.rep_load) begin
			out_data_q <= '{flow_total: total_q, node_index: rep_q,
				source_side: seen_q[QW'(rep_q)], edge_overflow: overflow_q,
				last: rep_last};
		end
	end

	always_comb begin
		sts.src_ok   = {1'b0, src_q} < n_eff;
		sts.q_empty  = qh_q == qt_q;
		sts.scan_end = p_q == pair_cnt_q;
		sts.found    = hit && aug_mode && (ev_head == snk_q);
		sts.at_src   = cur_q == src_q;
		sts.rep_last = rep_last;
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`MFMC_ASSERT_IMP(a_pair_cnt_bound, clk, arst_n, 1'b1, pair_cnt_q <= PCW'(PAIRS))
	`MFMC_ASSERT_IMP(a_queue_order, clk, arst_n, 1'b1, qh_q <= qt_q)
	`MFMC_ASSERT_NXT(a_overflow_sticky, clk, arst_n, overflow_q, overflow_q)

endmodule

// ----- rtl/mfmc_ctrl.sv -----
// ----------------------------------------------------------------------------
// mfmc_ctrl
// sequencer for edge loads, searches, augments and the cut report
// ----------------------------------------------------------------------------
`include "max_flow_min_cut_engine_top_macros.svh"

module mfmc_ctrl import mfmc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  func_t func,
	output logic  in_ready,
	input  sts_t  sts,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && func == FUNC_RUN) state_d = S_START;
			end
			S_START: state_d = sts.src_ok ? S_INIT : S_REP;
			S_INIT:  state_d = S_DEQ;
			S_DEQ:   state_d = sts.q_empty ? S_REP : S_LOAD;
			S_LOAD:  state_d = S_SRD;
			S_SRD:   state_d = sts.scan_end ? S_DEQ : S_E0;
			S_E0:    state_d = sts.found ? S_AUG : S_E1;
			S_E1:    state_d = sts.found ? S_AUG : S_SRD;
			S_AUG:   state_d = S_APAR;
			S_APAR:  state_d = sts.at_src ? S_INIT : S_AEDGE;
			S_AEDGE: state_d = S_AUPD;
			S_AUPD:  state_d = S_APAR;
			S_REP: begin
				if (sts.out_free && sts.rep_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.add      = accept && func == FUNC_ADD;
				cmd.run_load = accept && func == FUNC_RUN;
			end
			S_START: cmd.clr_seen    = !sts.src_ok;
			S_INIT:  cmd.init_search = 1'b1;
			S_LOAD:  cmd.load_u      = 1'b1;
			S_E0: begin
				cmd.eval = 1'b1;
			end
			S_E1: begin
				cmd.eval      = 1'b1;
				cmd.half      = 1'b1;
				cmd.pair_next = 1'b1;
			end
			S_AUG:   cmd.aug_start = 1'b1;
			S_AEDGE: cmd.edge_rd   = 1'b1;
			S_AUPD:  cmd.aug_upd   = 1'b1;
			S_REP:   cmd.rep_load  = sts.out_free;
			default: cmd = '0;
		endcase
	end

	`MFMC_ASSERT_IMP(a_busy_not_ready, clk, arst_n, state_q != S_IDLE, !in_ready)

endmodule

// ----- rtl/max_flow_min_cut_engine_top.sv -----
// ----------------------------------------------------------------------------
// max_flow_min_cut_engine_top
// edmonds-karp max flow over a stored edge table with a min-cut report
// ----------------------------------------------------------------------------
// An add beat writes one table word (edge plus reverse residual), or sets
// the sticky edge overflow flag instead when the table is full. A run beat
// takes a variable time set by the edge table walk: every breadth-first
// search scans each stored edge pair in both directions for each dequeued
// node, and a search stops early once the sink is reached. Each augment
// walks the path back from the sink and updates one edge pair per step. The
// report follows the start state directly when the source is out of range
// and otherwise after the last search, then gives one result beat per
// cycle while out_ready is high, one beat per node with node_count clamped
// to the range 2 to MAX_NODES. No clearing pass runs after reset.

module max_flow_min_cut_engine_top import mfmc_pkg::*; #(
	parameter int MAX_NODES = DEF_MAX_NODES,
	parameter int MAX_EDGES = DEF_MAX_EDGES
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  in_item_t        in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output out_item_t       out_data,
	input  logic            cfg_we,
	input  logic [NC_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	mfmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (in_data.func),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mfmc_datapath #(
		.MAX_NODES (MAX_NODES),
		.MAX_EDGES (MAX_EDGES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
